FILE: hdl/sipa_pkg.sv
package sipa_pkg;

   localparam int NUM_PORTS  = 64;
   localparam int NUM_QUEUES = 8;
   localparam int SLOTS      = NUM_PORTS * NUM_QUEUES;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_BYTES         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RESERVE_BYTES        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESUME_OFFSET_BYTES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PORT_HEADROOM_BYTES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_SHIFT          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_HEADROOM_BYTES = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_RESERVED_BYTES = 3'd6;

   localparam logic [31:0] RST_BUFFER_BYTES        = 32'(12 * 1024 * 1024);
   localparam logic [20:0] RST_RESERVE_BYTES       = 21'(4 * 1024);
   localparam logic [20:0] RST_RESUME_OFFSET_BYTES = 21'(3 * 1024);

   localparam logic OP_ARRIVAL   = 1'b0;
   localparam logic OP_DEPARTURE = 1'b1;

   localparam logic [1:0] PFC_NONE   = 2'd0;
   localparam logic [1:0] PFC_PAUSE  = 2'd1;
   localparam logic [1:0] PFC_RESUME = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [5:0]  port;
      logic [2:0]  queue;
      logic [13:0] packet_bytes;
   } req_type;

   typedef struct packed {
      logic        admitted;
      logic [1:0]  pfc_action;
      logic [31:0] shared_in_use;
   } rsp_type;

   typedef struct packed {
      logic [20:0] reserve_bytes;
      logic [20:0] resume_offset_bytes;
      logic [23:0] port_headroom_bytes;
      logic [4:0]  alpha_shift;
      logic [31:0] free_base;
      logic        settling;
   } cfg_type;

   typedef struct packed {
      logic              operation;
      logic              in_range;
      logic [SLOT_W-1:0] slot;
      logic [13:0]       packet_bytes;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } fq_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef struct packed {
      logic        pause;
      logic [31:0] headroom;
      logic [31:0] ingress;
   } entry_type;

   function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
   endfunction

endpackage

FILE: hdl/sipa_csr.sv
module sipa_csr import sipa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output cfg_type              cfg
);

   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   logic [31:0] buffer_ff, buffer_in;
   logic [20:0] reserve_ff, reserve_in;
   logic [20:0] resume_ff, resume_in;
   logic [23:0] port_hdr_ff, port_hdr_in;
   logic [4:0]  alpha_ff, alpha_in;
   logic [31:0] tot_hdr_ff, tot_hdr_in;
   logic [31:0] tot_res_ff, tot_res_in;
   logic [31:0] part_ff, part_in;
   logic [31:0] base_ff, base_in;
   logic [1:0]  settle_ff, settle_in;

   assign csr_ready = 1'b1;

   always_comb begin
      buffer_in   = buffer_ff;
      reserve_in  = reserve_ff;
      resume_in   = resume_ff;
      port_hdr_in = port_hdr_ff;
      alpha_in    = alpha_ff;
      tot_hdr_in  = tot_hdr_ff;
      tot_res_in  = tot_res_ff;
      settle_in   = (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;
      if (csr_valid) begin
         settle_in = SETTLE_CYCLES;
         unique case (csr_index)
            REG_BUFFER_BYTES:         buffer_in   = csr_data;
            REG_RESERVE_BYTES:        reserve_in  = csr_data[20:0];
            REG_RESUME_OFFSET_BYTES:  resume_in   = csr_data[20:0];
            REG_PORT_HEADROOM_BYTES:  port_hdr_in = csr_data[23:0];
            REG_ALPHA_SHIFT:          alpha_in    = csr_data[4:0];
            REG_TOTAL_HEADROOM_BYTES: tot_hdr_in  = csr_data;
            REG_TOTAL_RESERVED_BYTES: tot_res_in  = csr_data;
            default: ;
         endcase
      end
      // free pool before shared usage, two saturating steps registered in part_ff then base_ff
      part_in = sat_sub32(buffer_ff, tot_hdr_ff);
      base_in = sat_sub32(part_ff, tot_res_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff   <= RST_BUFFER_BYTES;
         reserve_ff  <= RST_RESERVE_BYTES;
         resume_ff   <= RST_RESUME_OFFSET_BYTES;
         port_hdr_ff <= '0;
         alpha_ff    <= '0;
         tot_hdr_ff  <= '0;
         tot_res_ff  <= '0;
         settle_ff   <= SETTLE_CYCLES;
      end else begin
         buffer_ff   <= buffer_in;
         reserve_ff  <= reserve_in;
         resume_ff   <= resume_in;
         port_hdr_ff <= port_hdr_in;
         alpha_ff    <= alpha_in;
         tot_hdr_ff  <= tot_hdr_in;
         tot_res_ff  <= tot_res_in;
         settle_ff   <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      base_ff <= base_in;
   end

   assign cfg.reserve_bytes       = reserve_ff;
   assign cfg.resume_offset_bytes = resume_ff;
   assign cfg.port_headroom_bytes = port_hdr_ff;
   assign cfg.alpha_shift         = alpha_ff;
   assign cfg.free_base           = base_ff;
   assign cfg.settling            = (settle_ff != 2'd0);

endmodule

FILE: hdl/sipa_front.sv
module sipa_front import sipa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  back_ctl_type ctl,
   output fq_type       fq
);

   job_type    q_ff [2];
   job_type    job_in;
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2) || ctl.clearing;
   assign push      = req_valid && !req_stall;

   always_comb begin
      job_in.operation    = req_data.operation;
      job_in.in_range     = (32'(req_data.port) < NUM_PORTS) &&
                            (32'(req_data.queue) < NUM_QUEUES);
      job_in.slot         = SLOT_W'(32'(req_data.port) * NUM_QUEUES + 32'(req_data.queue));
      job_in.packet_bytes = req_data.packet_bytes;

      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = ctl.pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, ctl.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= job_in;
      end
   end

   assign fq.valid = (cnt_ff != 2'd0);
   assign fq.job   = q_ff[rp_ff];

endmodule

FILE: hdl/sipa_back.sv
module sipa_back import sipa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  fq_type       fq,
   output back_ctl_type ctl,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LOAD   = 7'b0000100,
      ST_DECIDE = 7'b0001000,
      ST_UPDATE = 7'b0010000,
      ST_THRESH = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   entry_type mem [SLOTS];

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   job_type           job_ff, job_in;
   entry_type         rd_ff;
   logic [31:0]       ing_ff, ing_in;
   logic [31:0]       hdr_ff, hdr_in;
   logic              pause_ff, pause_in;
   logic [31:0]       used_ff, used_in;
   logic [32:0]       n_ff, n_in;
   logic [32:0]       hsum_ff, hsum_in;
   logic [13:0]       fromh_ff, fromh_in;
   logic [31:0]       thr_ff, thr_in;
   logic [31:0]       free_ff, free_in;
   logic              skip_ff, skip_in;
   logic [31:0]       new_ing_ff, new_ing_in;
   logic [31:0]       new_hdr_ff, new_hdr_in;
   logic [13:0]       delta_ff, delta_in;
   logic              dadd_ff, dadd_in;
   logic [31:0]       shared_ff, shared_in;
   logic [31:0]       used2_ff, used2_in;
   logic [32:0]       uoff_ff, uoff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              out_free;
   logic              rd_en;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   entry_type         mem_wd;
   logic [32:0]       size33;
   logic [32:0]       usum;
   logic [32:0]       over;
   logic              drop;
   logic [13:0]       rest;
   logic [32:0]       ssum;
   logic [31:0]       thr_now;
   logic              pause_new;
   logic [1:0]        action;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign size33   = 33'(job_ff.packet_bytes);
   assign usum     = {1'b0, used_ff} + size33;
   assign over     = n_ff - 33'(cfg.reserve_bytes);
   assign rest     = job_ff.packet_bytes - fromh_ff;
   assign drop     = (job_ff.operation == OP_ARRIVAL) &&
                     (hsum_ff > 33'(cfg.port_headroom_bytes)) &&
                     (usum > {1'b0, thr_ff});
   assign ssum     = {1'b0, shared_ff} + 33'(delta_ff);
   assign thr_now  = free_ff >> cfg.alpha_shift;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      ing_in       = ing_ff;
      hdr_in       = hdr_ff;
      pause_in     = pause_ff;
      used_in      = used_ff;
      n_in         = n_ff;
      hsum_in      = hsum_ff;
      fromh_in     = fromh_ff;
      thr_in       = thr_ff;
      free_in      = free_ff;
      skip_in      = skip_ff;
      new_ing_in   = new_ing_ff;
      new_hdr_in   = new_hdr_ff;
      delta_in     = delta_ff;
      dadd_in      = dadd_ff;
      shared_in    = shared_ff;
      used2_in     = used2_ff;
      uoff_in      = uoff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = job_ff.slot;
      mem_wd       = '0;
      pause_new    = pause_ff;
      action       = PFC_NONE;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // hold off while a new register value ripples into free_base
            if (fq.valid && !cfg.settling) begin
               rd_en    = 1'b1;
               job_in   = fq.job;
               free_in  = sat_sub32(cfg.free_base, shared_ff);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ing_in   = rd_ff.ingress;
            hdr_in   = rd_ff.headroom;
            pause_in = rd_ff.pause;
            used_in  = sat_sub32(rd_ff.ingress, 32'(cfg.reserve_bytes));
            n_in     = {1'b0, rd_ff.ingress} + size33;
            hsum_in  = {1'b0, rd_ff.headroom} + size33;
            fromh_in = (rd_ff.headroom < 32'(job_ff.packet_bytes)) ?
                       rd_ff.headroom[13:0] : job_ff.packet_bytes;
            thr_in   = free_ff >> cfg.alpha_shift;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            skip_in    = !job_ff.in_range || drop;
            new_ing_in = ing_ff;
            new_hdr_in = hdr_ff;
            delta_in   = '0;
            dadd_in    = 1'b1;
            if (job_ff.operation == OP_ARRIVAL) begin
               if (n_ff <= 33'(cfg.reserve_bytes)) begin
                  new_ing_in = n_ff[31:0];
               end else if (over > {1'b0, thr_ff}) begin
                  new_hdr_in = hsum_ff[32] ? '1 : hsum_ff[31:0];
               end else begin
                  new_ing_in = n_ff[32] ? '1 : n_ff[31:0];
                  delta_in   = (over < size33) ? over[13:0] : job_ff.packet_bytes;
               end
            end else begin
               // departure drains headroom first
               new_hdr_in = hdr_ff - 32'(fromh_ff);
               new_ing_in = sat_sub32(ing_ff, 32'(rest));
               delta_in   = (32'(rest) < used_ff) ? rest : used_ff[13:0];
               dadd_in    = 1'b0;
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!skip_ff) begin
               if (dadd_ff) begin
                  shared_in = ssum[32] ? '1 : ssum[31:0];
               end else begin
                  shared_in = sat_sub32(shared_ff, 32'(delta_ff));
               end
            end
            used2_in = sat_sub32(new_ing_ff, 32'(cfg.reserve_bytes));
            state_in = ST_THRESH;
         end
         ST_THRESH: begin
            free_in  = sat_sub32(cfg.free_base, shared_ff);
            uoff_in  = {1'b0, used2_ff} + 33'(cfg.resume_offset_bytes);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!pause_ff && (new_hdr_ff != 32'd0 || used2_ff >= thr_now)) begin
               pause_new = 1'b1;
               action    = PFC_PAUSE;
            end else if (pause_ff && new_hdr_ff == 32'd0 &&
                         (used2_ff == 32'd0 || uoff_ff <= {1'b0, thr_now})) begin
               pause_new = 1'b0;
               action    = PFC_RESUME;
            end
            if (out_free) begin
               mem_we                = !skip_ff;
               mem_wd.pause          = pause_new;
               mem_wd.headroom       = new_hdr_ff;
               mem_wd.ingress        = new_ing_ff;
               rsp_valid_in          = 1'b1;
               rsp_in.admitted       = !skip_ff;
               rsp_in.pfc_action     = skip_ff ? PFC_NONE : action;
               rsp_in.shared_in_use  = shared_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         shared_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         shared_ff    <= shared_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      ing_ff     <= ing_in;
      hdr_ff     <= hdr_in;
      pause_ff   <= pause_in;
      used_ff    <= used_in;
      n_ff       <= n_in;
      hsum_ff    <= hsum_in;
      fromh_ff   <= fromh_in;
      thr_ff     <= thr_in;
      free_ff    <= free_in;
      skip_ff    <= skip_in;
      new_ing_ff <= new_ing_in;
      new_hdr_ff <= new_hdr_in;
      delta_ff   <= delta_in;
      dadd_ff    <= dadd_in;
      used2_ff   <= used2_in;
      uoff_ff    <= uoff_in;
      rsp_ff     <= rsp_in;
   end

   // per queue counters, one entry per port and queue
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[fq.job.slot];
      end
   end

   assign ctl.pop      = rd_en;
   assign ctl.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

FILE: hdl/switch_ingress_pfc_admission.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_type: operation, port, queue, packet_bytes
// rsp_      out        rsp_valid/rsp_stall  rsp_type: admitted, pfc_action, shared_in_use
// csr_      in         csr_valid/csr_ready  csr_index, csr_data (ready is always high)
//
// each event passes through the back end as one queue-counter memory read, four arithmetic
// steps, then the write-back and result, held by rsp_stall; the next event starts right after
// after reset all 512 counter entries are zeroed, one entry a cycle, with req_stall high
// a 2-entry queue takes events until full while the back end works or rsp_stall holds it
// a register write holds off the next event start while derived limits settle
module switch_ingress_pfc_admission import sipa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type      cfg;
   fq_type       fq;
   back_ctl_type ctl;

   sipa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sipa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ctl       (ctl),
      .fq        (fq)
   );

   sipa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fq        (fq),
      .ctl       (ctl),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/sipa_checker.sv
module sipa_checker import sipa_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // counter memory is being cleared right after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open during clearing pass");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // dropped or ignored transaction never signals pause or resume
   a_drop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.admitted || rsp_data.pfc_action == PFC_NONE))
      else $error("pfc action on a dropped transaction");

endmodule

bind switch_ingress_pfc_admission sipa_checker u_sipa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
